### rtl/rnti_table_with_expiry_defines.svh
// assertion macros for the identifier aging table
`ifndef RNTI_TABLE_WITH_EXPIRY_DEFINES_SVH
`define RNTI_TABLE_WITH_EXPIRY_DEFINES_SVH

// property that must hold at every edge outside reset
`define RTE_CHECK(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication
`define RTE_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RTE_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rte_pkg.sv
// shared types and constants for the identifier aging table
package rte_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;
   localparam logic [31:0] EXPIRY_RESET = 32'd5000;

   localparam logic [1:0] KIND_DISCOVER = 2'd0;
   localparam logic [1:0] KIND_GRANT    = 2'd1;

   localparam logic REG_EXPIRY = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_APPEND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [4:0] known_count;
      logic       was_known;
      logic       inserted;
      logic       refreshed;
      logic       full_drop;
      logic [4:0] expired_count;
   } result_type;

endpackage

### rtl/rte_store.sv
// identifier and timestamp memories, one write and one registered read port
module rte_store #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
   input  logic [15:0]                    wr_id,
   input  logic [31:0]                    wr_stamp,
   input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
   output logic [15:0]                    rd_id,
   output logic [31:0]                    rd_stamp
);
   import rte_pkg::*;

   logic [15:0] id_mem [MAX_ENTRIES];
   logic [31:0] stamp_mem [MAX_ENTRIES];
   logic [15:0] rd_id_ff;
   logic [31:0] rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr]    <= wr_id;
         stamp_mem[wr_addr] <= wr_stamp;
      end
   end

   always_ff @(posedge clock) begin
      rd_id_ff    <= id_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   assign rd_id    = rd_id_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule

### rtl/rte_age.sv
// age subtract and expiry compare shared by every entry of the walk
module rte_age (
   input  logic [31:0] now_ms,
   input  logic [31:0] stamp,
   input  logic [31:0] expiry_ms,
   output logic        expired
);
   import rte_pkg::*;

   logic [31:0] age;

   assign age     = now_ms - stamp;
   assign expired = age > expiry_ms;

endmodule

### rtl/rte_seq.sv
// sequencer: one pass over the table for search, refresh and pruning, then append
`include "rnti_table_with_expiry_defines.svh"

module rte_seq #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_kind,
   input  logic [15:0]                    req_rnti,
   input  logic [3:0]                     req_entry_index,
   input  logic [31:0]                    req_now_ms,
   input  logic [31:0]                    expiry_ms,
   output logic                           mem_wr_en,
   output logic [$clog2(MAX_ENTRIES)-1:0] mem_wr_addr,
   output logic [15:0]                    mem_wr_id,
   output logic [31:0]                    mem_wr_stamp,
   output logic [$clog2(MAX_ENTRIES)-1:0] mem_rd_addr,
   input  logic [15:0]                    mem_rd_id,
   input  logic [31:0]                    mem_rd_stamp,
   output logic                           res_valid,
   input  logic                           res_load,
   output rte_pkg::result_type            res
);
   import rte_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int PW = (CW > 4) ? CW : 4;

   state_type   state_ff, state_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] rnti_ff, rnti_in;
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] now_ff, now_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ff, rd_in;
   logic [CW-1:0] wr_ff, wr_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] pidx_ff, pidx_in;
   logic        pend_ff, pend_in;
   logic        known_ff, known_in;
   logic        refr_ff, refr_in;
   logic        ins_ff, ins_in;
   logic        drop_ff, drop_in;

   logic        issue;
   logic        id_hit;
   logic        refresh;
   logic [31:0] stamp;
   logic        expired;
   logic        full;
   logic        ins_now;

   rte_age u_age (
      .now_ms    (now_ff),
      .stamp     (stamp),
      .expiry_ms (expiry_ms),
      .expired   (expired)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      rnti_ff  <= rnti_in;
      pos_ff   <= pos_in;
      now_ff   <= now_in;
      rd_ff    <= rd_in;
      wr_ff    <= wr_in;
      rem_ff   <= rem_in;
      pidx_ff  <= pidx_in;
      known_ff <= known_in;
      refr_ff  <= refr_in;
      ins_ff   <= ins_in;
      drop_ff  <= drop_in;
   end

   assign issue   = rd_ff < count_ff;
   assign id_hit  = mem_rd_id == rnti_ff;
   assign refresh = (kind_ff == KIND_GRANT) && (PW'(pidx_ff) == PW'(pos_ff)) && id_hit;
   assign stamp   = refresh ? now_ff : mem_rd_stamp;
   assign full    = count_ff == CW'(MAX_ENTRIES);
   assign ins_now = (kind_ff == KIND_DISCOVER) && !known_ff && !full;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      rnti_in      = rnti_ff;
      pos_in       = pos_ff;
      now_in       = now_ff;
      count_in     = count_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      rem_in       = rem_ff;
      pidx_in      = pidx_ff;
      pend_in      = 1'b0;
      known_in     = known_ff;
      refr_in      = refr_ff;
      ins_in       = ins_ff;
      drop_in      = drop_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_ff[AW-1:0];
      mem_wr_id    = mem_rd_id;
      mem_wr_stamp = stamp;
      mem_rd_addr  = rd_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in  = req_kind;
               rnti_in  = req_rnti;
               pos_in   = req_entry_index;
               now_in   = req_now_ms;
               rd_in    = '0;
               wr_in    = '0;
               rem_in   = '0;
               known_in = 1'b0;
               refr_in  = 1'b0;
               ins_in   = 1'b0;
               drop_in  = 1'b0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (issue) begin
               rd_in   = rd_ff + CW'(1);
               pidx_in = rd_ff;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if ((kind_ff == KIND_DISCOVER) && id_hit) begin
                  known_in = 1'b1;
               end
               if (refresh) begin
                  refr_in = 1'b1;
               end
               if (expired) begin
                  rem_in = rem_ff + CW'(1);
               end else begin
                  mem_wr_en = 1'b1;
                  wr_in     = wr_ff + CW'(1);
               end
            end
            if (!issue && !pend_ff) begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            // fresh entry goes after the survivors
            mem_wr_en    = ins_now;
            mem_wr_id    = rnti_ff;
            mem_wr_stamp = now_ff;
            ins_in       = ins_now;
            drop_in      = (kind_ff == KIND_DISCOVER) && !known_ff && full;
            count_in     = CW'(wr_ff + CW'(ins_now));
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res.known_count   = 5'(count_ff);
   assign res.was_known     = known_ff;
   assign res.inserted      = ins_ff;
   assign res.refreshed     = refr_ff;
   assign res.full_drop     = drop_ff;
   assign res.expired_count = 5'(rem_ff);

   `RTE_CHECK(a_count_max, count_ff <= CW'(MAX_ENTRIES), "entry count above table depth")
   `RTE_IMPLY(a_wr_behind, (state_ff == ST_WALK) && pend_ff, wr_ff <= pidx_ff,
              "compaction write overtook the read pointer")
   `RTE_IMPLY(a_flags_excl, state_ff == ST_DONE, $onehot0({known_ff, ins_ff, refr_ff, drop_ff}),
              "more than one result flag set")
   `RTE_NEXT(a_start_walk, (state_ff == ST_IDLE) && req_valid, state_ff == ST_WALK,
             "accepted request did not start the walk")

endmodule

### rtl/rnti_table_with_expiry.sv
// top level: identifier aging table with register port and response register
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | kind, rnti, entry_index, now_ms
//   rsp     | out       | rsp_valid/rsp_stall | known_count, flags, expired_count
//   csr     | in/out    | psel/penable/pready | expiry_ms at byte address 0
//
// an accepted request walks the entries held one entry per cycle through the single age
// compare unit and memory read port, then passes the append and done states; the response
// register loads from the done state, and the next request can be taken in the cycle after
// reset clears the entry count and loads expiry_ms with 5000; table memory is not cleared
// a held response blocks completion of the next request, not its acceptance
module rnti_table_with_expiry #(
   parameter int MAX_ENTRIES = rte_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_rnti,
   input  logic [3:0]  req_entry_index,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_known_count,
   output logic        rsp_was_known,
   output logic        rsp_inserted,
   output logic        rsp_refreshed,
   output logic        rsp_full_drop,
   output logic [4:0]  rsp_expired_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rte_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);

   logic [31:0] expiry_ff, expiry_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   logic          req_ready;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [15:0]   mem_wr_id;
   logic [31:0]   mem_wr_stamp;
   logic [AW-1:0] mem_rd_addr;
   logic [15:0]   mem_rd_id;
   logic [31:0]   mem_rd_stamp;
   logic          res_valid;
   logic          res_load;
   result_type    res;
   logic          csr_wr;

   rte_store #(.MAX_ENTRIES(MAX_ENTRIES)) u_store (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_id    (mem_wr_id),
      .wr_stamp (mem_wr_stamp),
      .rd_addr  (mem_rd_addr),
      .rd_id    (mem_rd_id),
      .rd_stamp (mem_rd_stamp)
   );

   rte_seq #(.MAX_ENTRIES(MAX_ENTRIES)) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_rnti        (req_rnti),
      .req_entry_index (req_entry_index),
      .req_now_ms      (req_now_ms),
      .expiry_ms       (expiry_ff),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_id       (mem_wr_id),
      .mem_wr_stamp    (mem_wr_stamp),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_id       (mem_rd_id),
      .mem_rd_stamp    (mem_rd_stamp),
      .res_valid       (res_valid),
      .res_load        (res_load),
      .res             (res)
   );

   assign req_stall = !req_ready;
   assign res_load  = !rsp_valid_ff || !rsp_stall;

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_EXPIRY);

   always_comb begin
      expiry_in    = expiry_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (csr_wr) begin
         expiry_in = csr_pwdata;
      end
      if (res_load) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expiry_ff    <= EXPIRY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         expiry_ff    <= expiry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign csr_prdata = (csr_paddr[2] == REG_EXPIRY) ? expiry_ff : 32'd0;
   assign csr_pready = 1'b1;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_known_count   = rsp_ff.known_count;
   assign rsp_was_known     = rsp_ff.was_known;
   assign rsp_inserted      = rsp_ff.inserted;
   assign rsp_refreshed     = rsp_ff.refreshed;
   assign rsp_full_drop     = rsp_ff.full_drop;
   assign rsp_expired_count = rsp_ff.expired_count;

endmodule
